// File: hdl/look_at_view_matrix_core_assert.svh
// assertion macros for the look-at core checker
`ifndef LOOK_AT_VIEW_MATRIX_CORE_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_ASSERT_SVH

// same-cycle implication
`define LAVM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LAVM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lavm_pkg.sv
package lavm_pkg;

  localparam int WORD_W = 32;
  localparam int ITEM_CYCLES = 4;
  localparam logic [1:0] COL_LAST = 2'd3;

  // normalizer: magnitudes scaled into [2^29, 2^30)
  localparam int NORM_MW = 30;
  localparam int NORM_TOP = 29;
  localparam int NORM_SW = 62;
  localparam int NORM_RW = 31;

  // signed width of a rounded translation term before saturation
  localparam int DOT_TW = 38;

  typedef struct packed {
    logic signed [WORD_W-1:0] eye_x;
    logic signed [WORD_W-1:0] eye_y;
    logic signed [WORD_W-1:0] eye_z;
    logic signed [WORD_W-1:0] target_x;
    logic signed [WORD_W-1:0] target_y;
    logic signed [WORD_W-1:0] target_z;
    logic signed [WORD_W-1:0] up_x;
    logic signed [WORD_W-1:0] up_y;
    logic signed [WORD_W-1:0] up_z;
  } lavm_in_t;

  typedef struct packed {
    logic [1:0]               column_index;
    logic signed [WORD_W-1:0] entry_0;
    logic signed [WORD_W-1:0] entry_1;
    logic signed [WORD_W-1:0] entry_2;
    logic signed [WORD_W-1:0] entry_3;
    logic                     degenerate;
    logic                     last_column;
  } lavm_out_t;

  function automatic logic [WORD_W-1:0] sat_word(input logic signed [DOT_TW-1:0] v);
    logic signed [DOT_TW-1:0] hi;
    logic signed [DOT_TW-1:0] lo;
    hi = $signed({{(DOT_TW-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}});
    lo = $signed({{(DOT_TW-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}});
    if (v > hi) begin
      return hi[WORD_W-1:0];
    end else if (v < lo) begin
      return lo[WORD_W-1:0];
    end
    return v[WORD_W-1:0];
  endfunction

endpackage

// File: hdl/lavm_norm.sv
module lavm_norm
  import lavm_pkg::*;
#(
  parameter int CW = 33,
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [2:0][CW-1:0]         in_comp,
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  output logic [2:0][FRAC_BITS+1:0]  out_comp,
  output logic                       out_zero,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int PBW = $clog2(CW);
  localparam int OW = FRAC_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int NW = NORM_MW + FRAC_BITS + 1;
  localparam int DQ = FRAC_BITS + 1;
  localparam int KW = SIDE_W + 3;
  localparam int XW = CW + NORM_MW;

  // stage 0: magnitudes and signs
  logic                 s0_v_r;
  logic [2:0][CW-1:0]   s0_mag_r;
  logic [KW-1:0]        s0_pk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s0_mag_r[i] <= in_comp[i][CW-1] ? (~in_comp[i] + 1'b1) : in_comp[i];
    end
    s0_pk_r <= {in_side, in_comp[2][CW-1], in_comp[1][CW-1], in_comp[0][CW-1]};
  end

  // stage 1: leading one of the largest magnitude
  logic [CW-1:0]        orv_c;
  logic [PBW-1:0]       p_c;
  logic                 s1_v_r;
  logic [PBW-1:0]       s1_p_r;
  logic                 s1_zero_r;
  logic [2:0][CW-1:0]   s1_mag_r;
  logic [KW-1:0]        s1_pk_r;

  assign orv_c = s0_mag_r[0] | s0_mag_r[1] | s0_mag_r[2];

  always_comb begin
    p_c = '0;
    for (int b = 0; b < CW; b++) begin
      if (orv_c[b]) begin
        p_c = PBW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_p_r    <= p_c;
    s1_zero_r <= (orv_c == '0);
    s1_mag_r  <= s0_mag_r;
    s1_pk_r   <= s0_pk_r;
  end

  // stage 2: common shift into [2^29, 2^30)
  logic [XW-1:0]             sh_c [3];
  logic                      s2_v_r;
  logic                      s2_zero_r;
  logic [2:0][NORM_MW-1:0]   s2_mag_r;
  logic [KW-1:0]             s2_pk_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s1_p_r >= PBW'(NORM_TOP)) begin
        sh_c[i] = {{NORM_MW{1'b0}}, s1_mag_r[i]} >> (s1_p_r - PBW'(NORM_TOP));
      end else begin
        sh_c[i] = {{NORM_MW{1'b0}}, s1_mag_r[i]} << (PBW'(NORM_TOP) - s1_p_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_mag_r[i] <= sh_c[i][NORM_MW-1:0];
    end
    s2_zero_r <= s1_zero_r;
    s2_pk_r   <= s1_pk_r;
  end

  // stage 3: squares
  logic                        s3_v_r;
  logic                        s3_zero_r;
  logic [2*NORM_MW-1:0]        s3_sq_r [3];
  logic [2:0][NORM_MW-1:0]     s3_mag_r;
  logic [KW-1:0]               s3_pk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_sq_r[i] <= s2_mag_r[i] * s2_mag_r[i];
    end
    s3_mag_r  <= s2_mag_r;
    s3_zero_r <= s2_zero_r;
    s3_pk_r   <= s2_pk_r;
  end

  // stage 4 and square root, one result bit per stage
  logic                      sq_v_r    [0:NORM_RW];
  logic [NORM_RW-1:0]        sq_root_r [0:NORM_RW];
  logic [NORM_RW+2:0]        sq_rem_r  [0:NORM_RW];
  logic [NORM_SW-1:0]        sq_x_r    [0:NORM_RW];
  logic [2:0][NORM_MW-1:0]   sq_mag_r  [0:NORM_RW];
  logic [KW-1:0]             sq_pk_r   [0:NORM_RW];
  logic                      sq_zero_r [0:NORM_RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_x_r[0]    <= NORM_SW'(s3_sq_r[0]) + NORM_SW'(s3_sq_r[1]) + NORM_SW'(s3_sq_r[2]);
    sq_root_r[0] <= '0;
    sq_rem_r[0]  <= '0;
    sq_mag_r[0]  <= s3_mag_r;
    sq_pk_r[0]   <= s3_pk_r;
    sq_zero_r[0] <= s3_zero_r;
  end

  for (genvar k = 0; k < NORM_RW; k++) begin : g_sqrt
    logic [NORM_RW+2:0] rem_sh;
    logic [NORM_RW+2:0] trial;

    assign rem_sh = {sq_rem_r[k][NORM_RW:0], sq_x_r[k][NORM_SW-1-2*k -: 2]};
    assign trial  = {1'b0, sq_root_r[k], 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rem_sh >= trial) begin
        sq_rem_r[k+1]  <= rem_sh - trial;
        sq_root_r[k+1] <= {sq_root_r[k][NORM_RW-2:0], 1'b1};
      end else begin
        sq_rem_r[k+1]  <= rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][NORM_RW-2:0], 1'b0};
      end
      sq_x_r[k+1]    <= sq_x_r[k];
      sq_mag_r[k+1]  <= sq_mag_r[k];
      sq_pk_r[k+1]   <= sq_pk_r[k];
      sq_zero_r[k+1] <= sq_zero_r[k];
    end
  end

  // rounded division, one quotient bit per stage and lane
  logic                  dv_v_r    [0:DQ];
  logic [NW-1:0]         dv_rem_r  [0:DQ][3];
  logic [QW-1:0]         dv_q_r    [0:DQ][3];
  logic [NORM_RW-1:0]    dv_len_r  [0:DQ];
  logic [KW-1:0]         dv_pk_r   [0:DQ];
  logic                  dv_zero_r [0:DQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[NORM_RW];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      dv_rem_r[0][l] <= (NW'(sq_mag_r[NORM_RW][l]) << FRAC_BITS)
                        + NW'(sq_root_r[NORM_RW] >> 1);
      dv_q_r[0][l]   <= '0;
    end
    dv_len_r[0]  <= sq_root_r[NORM_RW];
    dv_pk_r[0]   <= sq_pk_r[NORM_RW];
    dv_zero_r[0] <= sq_zero_r[NORM_RW];
  end

  for (genvar k = 0; k < DQ; k++) begin : g_div
    localparam int SH = FRAC_BITS - k;
    logic [NW-1:0] dsh;

    assign dsh = NW'(dv_len_r[k]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 3; l++) begin
        if (dv_rem_r[k][l] >= dsh) begin
          dv_rem_r[k+1][l] <= dv_rem_r[k][l] - dsh;
          dv_q_r[k+1][l]   <= dv_q_r[k][l] | (QW'(1) << SH);
        end else begin
          dv_rem_r[k+1][l] <= dv_rem_r[k][l];
          dv_q_r[k+1][l]   <= dv_q_r[k][l];
        end
      end
      dv_len_r[k+1]  <= dv_len_r[k];
      dv_pk_r[k+1]   <= dv_pk_r[k];
      dv_zero_r[k+1] <= dv_zero_r[k];
    end
  end

  // sign restore
  logic [OW-1:0] qv_c [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qv_c[l] = {1'b0, dv_q_r[DQ][l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_v_r[DQ];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (dv_zero_r[DQ]) begin
        out_comp[l] <= '0;
      end else if (dv_pk_r[DQ][l]) begin
        out_comp[l] <= ~qv_c[l] + 1'b1;
      end else begin
        out_comp[l] <= qv_c[l];
      end
    end
    out_zero <= dv_zero_r[DQ];
    out_side <= dv_pk_r[DQ][KW-1:3];
  end

endmodule

// File: hdl/look_at_view_matrix_core.sv
// Look-at view matrix core. A camera word (eye, target, up in signed fixed point with
// FRAC_BITS fraction bits) is taken at a clock edge where start is high and busy is low;
// busy then stays high while the gap counter runs down, so cameras enter no faster than
// the result port shows the four columns of one matrix. Each camera runs down a fixed
// pipeline of three normalizers (each a 31-stage square root and a FRAC_BITS+1 stage
// divider), and its columns 0..3 then appear back to back in rising order with
// out_valid high. The receiver cannot stall the core: every column word must be
// captured in the cycle it is shown.
module look_at_view_matrix_core
  import lavm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  lavm_in_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output lavm_out_t out_data
);

  localparam int OW  = FRAC_BITS + 2;
  localparam int DCW = WORD_W + 1;
  localparam int PW1 = OW + WORD_W;
  localparam int SCW = PW1 + 1;
  localparam int PW2 = 2 * OW;
  localparam int UCW = PW2 + 1;
  localparam int DW  = PW1 + 2;
  localparam int RW8 = DW - FRAC_BITS;
  localparam int EW  = 3 * WORD_W;
  localparam int SW1 = 2 * EW;
  localparam int SW2 = EW + 3 * OW + 1;
  localparam int SW3 = EW + 6 * OW + 1;

  // input throttle
  logic [1:0] gap_r;
  logic       acc;

  assign busy = (gap_r != '0);
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (acc) begin
      gap_r <= 2'(ITEM_CYCLES - 1);
    end else if (busy) begin
      gap_r <= gap_r - 2'd1;
    end
  end

  // direction
  logic                      t0_v_r;
  logic [2:0][DCW-1:0]       t0_dir_r;
  logic [2:0][WORD_W-1:0]    t0_eye_r;
  logic [2:0][WORD_W-1:0]    t0_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r <= 1'b0;
    end else begin
      t0_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    t0_dir_r[0] <= {in_data.target_x[WORD_W-1], in_data.target_x}
                   - {in_data.eye_x[WORD_W-1], in_data.eye_x};
    t0_dir_r[1] <= {in_data.target_y[WORD_W-1], in_data.target_y}
                   - {in_data.eye_y[WORD_W-1], in_data.eye_y};
    t0_dir_r[2] <= {in_data.target_z[WORD_W-1], in_data.target_z}
                   - {in_data.eye_z[WORD_W-1], in_data.eye_z};
    t0_eye_r    <= {in_data.eye_z, in_data.eye_y, in_data.eye_x};
    t0_up_r     <= {in_data.up_z, in_data.up_y, in_data.up_x};
  end

  // forward
  logic                    n1_v;
  logic [2:0][OW-1:0]      n1_f;
  logic                    n1_zero;
  logic [SW1-1:0]          n1_side;
  logic [2:0][WORD_W-1:0]  n1_eye;
  logic [2:0][WORD_W-1:0]  n1_up;

  lavm_norm #(.CW(DCW), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW1)) u_norm_f (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t0_v_r),
    .in_comp   (t0_dir_r),
    .in_side   ({t0_eye_r, t0_up_r}),
    .out_valid (n1_v),
    .out_comp  (n1_f),
    .out_zero  (n1_zero),
    .out_side  (n1_side)
  );

  assign n1_eye = n1_side[SW1-1 -: EW];
  assign n1_up  = n1_side[EW-1:0];

  // side = f x up
  logic                    t1_v_r;
  logic signed [PW1-1:0]   t1_p_r [6];
  logic [2:0][WORD_W-1:0]  t1_eye_r;
  logic [2:0][OW-1:0]      t1_f_r;
  logic                    t1_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else begin
      t1_v_r <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    t1_p_r[0] <= $signed(n1_f[1]) * $signed(n1_up[2]);
    t1_p_r[1] <= $signed(n1_f[2]) * $signed(n1_up[1]);
    t1_p_r[2] <= $signed(n1_f[2]) * $signed(n1_up[0]);
    t1_p_r[3] <= $signed(n1_f[0]) * $signed(n1_up[2]);
    t1_p_r[4] <= $signed(n1_f[0]) * $signed(n1_up[1]);
    t1_p_r[5] <= $signed(n1_f[1]) * $signed(n1_up[0]);
    t1_eye_r  <= n1_eye;
    t1_f_r    <= n1_f;
    t1_dg_r   <= n1_zero;
  end

  logic                    t2_v_r;
  logic [2:0][SCW-1:0]     t2_sv_r;
  logic [2:0][WORD_W-1:0]  t2_eye_r;
  logic [2:0][OW-1:0]      t2_f_r;
  logic                    t2_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
    end else begin
      t2_v_r <= t1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    t2_sv_r[0] <= SCW'(t1_p_r[0]) - SCW'(t1_p_r[1]);
    t2_sv_r[1] <= SCW'(t1_p_r[2]) - SCW'(t1_p_r[3]);
    t2_sv_r[2] <= SCW'(t1_p_r[4]) - SCW'(t1_p_r[5]);
    t2_eye_r   <= t1_eye_r;
    t2_f_r     <= t1_f_r;
    t2_dg_r    <= t1_dg_r;
  end

  logic                    n2_v;
  logic [2:0][OW-1:0]      n2_s;
  logic                    n2_zero;
  logic [SW2-1:0]          n2_side;
  logic [2:0][WORD_W-1:0]  n2_eye;
  logic [2:0][OW-1:0]      n2_f;

  lavm_norm #(.CW(SCW), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW2)) u_norm_s (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t2_v_r),
    .in_comp   (t2_sv_r),
    .in_side   ({t2_eye_r, t2_f_r, t2_dg_r}),
    .out_valid (n2_v),
    .out_comp  (n2_s),
    .out_zero  (n2_zero),
    .out_side  (n2_side)
  );

  assign n2_eye = n2_side[SW2-1 -: EW];
  assign n2_f   = n2_side[3*OW:1];

  // true up = s x f
  logic                    t3_v_r;
  logic signed [PW2-1:0]   t3_p_r [6];
  logic [2:0][WORD_W-1:0]  t3_eye_r;
  logic [2:0][OW-1:0]      t3_f_r;
  logic [2:0][OW-1:0]      t3_s_r;
  logic                    t3_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_v_r <= 1'b0;
    end else begin
      t3_v_r <= n2_v;
    end
  end

  always_ff @(posedge clk) begin
    t3_p_r[0] <= $signed(n2_s[1]) * $signed(n2_f[2]);
    t3_p_r[1] <= $signed(n2_s[2]) * $signed(n2_f[1]);
    t3_p_r[2] <= $signed(n2_s[2]) * $signed(n2_f[0]);
    t3_p_r[3] <= $signed(n2_s[0]) * $signed(n2_f[2]);
    t3_p_r[4] <= $signed(n2_s[0]) * $signed(n2_f[1]);
    t3_p_r[5] <= $signed(n2_s[1]) * $signed(n2_f[0]);
    t3_eye_r  <= n2_eye;
    t3_f_r    <= n2_f;
    t3_s_r    <= n2_s;
    t3_dg_r   <= n2_side[0] | n2_zero;
  end

  logic                    t4_v_r;
  logic [2:0][UCW-1:0]     t4_uv_r;
  logic [2:0][WORD_W-1:0]  t4_eye_r;
  logic [2:0][OW-1:0]      t4_f_r;
  logic [2:0][OW-1:0]      t4_s_r;
  logic                    t4_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t4_v_r <= 1'b0;
    end else begin
      t4_v_r <= t3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    t4_uv_r[0] <= UCW'(t3_p_r[0]) - UCW'(t3_p_r[1]);
    t4_uv_r[1] <= UCW'(t3_p_r[2]) - UCW'(t3_p_r[3]);
    t4_uv_r[2] <= UCW'(t3_p_r[4]) - UCW'(t3_p_r[5]);
    t4_eye_r   <= t3_eye_r;
    t4_f_r     <= t3_f_r;
    t4_s_r     <= t3_s_r;
    t4_dg_r    <= t3_dg_r;
  end

  logic                    n3_v;
  logic [2:0][OW-1:0]      n3_u;
  logic                    n3_zero;
  logic [SW3-1:0]          n3_side;
  logic [2:0][WORD_W-1:0]  n3_eye;
  logic [2:0][OW-1:0]      n3_f;
  logic [2:0][OW-1:0]      n3_s;

  lavm_norm #(.CW(UCW), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW3)) u_norm_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t4_v_r),
    .in_comp   (t4_uv_r),
    .in_side   ({t4_eye_r, t4_f_r, t4_s_r, t4_dg_r}),
    .out_valid (n3_v),
    .out_comp  (n3_u),
    .out_zero  (n3_zero),
    .out_side  (n3_side)
  );

  assign n3_eye = n3_side[SW3-1 -: EW];
  assign n3_f   = n3_side[6*OW:3*OW+1];
  assign n3_s   = n3_side[3*OW:1];

  // translation: products with the eye, row 0 side, row 1 up, row 2 forward
  logic                    t5_v_r;
  logic signed [PW1-1:0]   t5_p_r [3][3];
  logic [2:0][OW-1:0]      t5_f_r;
  logic [2:0][OW-1:0]      t5_s_r;
  logic [2:0][OW-1:0]      t5_u_r;
  logic                    t5_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t5_v_r <= 1'b0;
    end else begin
      t5_v_r <= n3_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      t5_p_r[0][i] <= $signed(n3_s[i]) * $signed(n3_eye[i]);
      t5_p_r[1][i] <= $signed(n3_u[i]) * $signed(n3_eye[i]);
      t5_p_r[2][i] <= $signed(n3_f[i]) * $signed(n3_eye[i]);
    end
    t5_f_r  <= n3_f;
    t5_s_r  <= n3_s;
    t5_u_r  <= n3_u;
    t5_dg_r <= n3_side[0] | n3_zero;
  end

  logic                    t6_v_r;
  logic signed [DW-1:0]    t6_d_r [3];
  logic [2:0][OW-1:0]      t6_f_r;
  logic [2:0][OW-1:0]      t6_s_r;
  logic [2:0][OW-1:0]      t6_u_r;
  logic                    t6_dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t6_v_r <= 1'b0;
    end else begin
      t6_v_r <= t5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      t6_d_r[a] <= DW'(t5_p_r[a][0]) + DW'(t5_p_r[a][1]) + DW'(t5_p_r[a][2]);
    end
    t6_f_r  <= t5_f_r;
    t6_s_r  <= t5_s_r;
    t6_u_r  <= t5_u_r;
    t6_dg_r <= t5_dg_r;
  end

  // round half away from zero
  logic [DW-1:0]           mag_c [3];
  logic                    t7_v_r;
  logic [DW-1:0]           t7_rnd_r [3];
  logic [2:0]              t7_neg_r;
  logic [2:0][OW-1:0]      t7_f_r;
  logic [2:0][OW-1:0]      t7_s_r;
  logic [2:0][OW-1:0]      t7_u_r;
  logic                    t7_dg_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag_c[a] = t6_d_r[a][DW-1] ? (~t6_d_r[a] + 1'b1) : t6_d_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t7_v_r <= 1'b0;
    end else begin
      t7_v_r <= t6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      t7_rnd_r[a] <= mag_c[a] + (DW'(1) << (FRAC_BITS - 1));
      t7_neg_r[a] <= t6_d_r[a][DW-1];
    end
    t7_f_r  <= t6_f_r;
    t7_s_r  <= t6_s_r;
    t7_u_r  <= t6_u_r;
    t7_dg_r <= t6_dg_r;
  end

  logic signed [DOT_TW-1:0] pos_c [3];
  logic signed [DOT_TW-1:0] ngv_c [3];
  logic                     t8_v_r;
  logic [WORD_W-1:0]        t8_m_r [3];
  logic [2:0][OW-1:0]       t8_f_r;
  logic [2:0][OW-1:0]       t8_s_r;
  logic [2:0][OW-1:0]       t8_u_r;
  logic                     t8_dg_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos_c[a] = $signed({{(DOT_TW-RW8){1'b0}}, t7_rnd_r[a][DW-1:FRAC_BITS]});
      ngv_c[a] = -pos_c[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t8_v_r <= 1'b0;
    end else begin
      t8_v_r <= t7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    t8_m_r[0] <= sat_word(t7_neg_r[0] ? pos_c[0] : ngv_c[0]);
    t8_m_r[1] <= sat_word(t7_neg_r[1] ? pos_c[1] : ngv_c[1]);
    t8_m_r[2] <= sat_word(t7_neg_r[2] ? ngv_c[2] : pos_c[2]);
    t8_f_r    <= t7_f_r;
    t8_s_r    <= t7_s_r;
    t8_u_r    <= t7_u_r;
    t8_dg_r   <= t7_dg_r;
  end

  // column serializer
  logic                act_r;
  logic [1:0]          cnt_r;
  logic [WORD_W-1:0]   hold_m_r [3];
  logic [2:0][OW-1:0]  hold_f_r;
  logic [2:0][OW-1:0]  hold_s_r;
  logic [2:0][OW-1:0]  hold_u_r;
  logic                hold_dg_r;
  logic [OW-1:0]       nf_c;
  lavm_out_t           col_nxt;
  logic                out_valid_r;
  lavm_out_t           out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (t8_v_r) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else if (act_r) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == COL_LAST) begin
        act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (t8_v_r) begin
      hold_m_r  <= t8_m_r;
      hold_f_r  <= t8_f_r;
      hold_s_r  <= t8_s_r;
      hold_u_r  <= t8_u_r;
      hold_dg_r <= t8_dg_r;
    end
  end

  assign nf_c = ~hold_f_r[cnt_r] + 1'b1;

  always_comb begin
    col_nxt.column_index = cnt_r;
    col_nxt.degenerate   = hold_dg_r;
    col_nxt.last_column  = (cnt_r == COL_LAST);
    if (cnt_r == COL_LAST) begin
      col_nxt.entry_0 = hold_m_r[0];
      col_nxt.entry_1 = hold_m_r[1];
      col_nxt.entry_2 = hold_m_r[2];
      col_nxt.entry_3 = WORD_W'(1) << FRAC_BITS;
    end else begin
      col_nxt.entry_0 = {{(WORD_W-OW){hold_s_r[cnt_r][OW-1]}}, hold_s_r[cnt_r]};
      col_nxt.entry_1 = {{(WORD_W-OW){hold_u_r[cnt_r][OW-1]}}, hold_u_r[cnt_r]};
      col_nxt.entry_2 = {{(WORD_W-OW){nf_c[OW-1]}}, nf_c};
      col_nxt.entry_3 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= col_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/lavm_checker.sv
`include "look_at_view_matrix_core_assert.svh"

module lavm_checker
  import lavm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input lavm_out_t out_data
);

  // accepted camera word holds the input off
  `LAVM_ASSERT_NXT(a_busy_after_accept, start && !busy, busy, "busy low after accept")

  // columns of one matrix come back to back in rising order
  `LAVM_ASSERT_NXT(a_col_run, out_valid && !out_data.last_column, out_valid && (out_data.column_index == 2'($past(out_data.column_index) + 2'd1)), "column run broken")

  `LAVM_ASSERT_NOW(a_last_col, out_valid, out_data.last_column == (out_data.column_index == COL_LAST), "last column flag wrong")

  `LAVM_ASSERT_NXT(a_degen_hold, out_valid && !out_data.last_column, out_data.degenerate == $past(out_data.degenerate), "degenerate flag changed within matrix")

endmodule

bind look_at_view_matrix_core lavm_checker u_lavm_checker (.*);
